// ----- rtl/slcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Status LED color controller package
// Shared word types, command and status codes, state encodings and the
// breathing sine table used by the controller and its scaling lanes.
// ----------------------------------------------------------------------------
package slcc_pkg;

  // Timing constants of the controller.
  localparam int BREATHE_PERIOD_MS   = 2048;
  localparam int SINE_ENTRIES        = 256;
  localparam int REFRESH_INTERVAL_MS = 20;
  localparam int BLINK_HALF_MS       = 500;

  // Field and counter widths.
  localparam int CMD_W     = 3;
  localparam int CODE_W    = 3;
  localparam int COLOR_W   = 8;
  localparam int BRIGHT_W  = 8;
  localparam int PROD_W    = COLOR_W + BRIGHT_W;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int PHASE_W   = $clog2(BREATHE_PERIOD_MS + 1);
  localparam int REFRESH_W = $clog2(REFRESH_INTERVAL_MS + 1);
  localparam int ELAPSED_W = 10;
  localparam int IDX_W     = $clog2(SINE_ENTRIES);
  localparam int IDXP_W    = PHASE_W + IDX_W + 1;
  localparam int ROM_W     = 16;
  localparam int ROM_FRAC  = 15;
  localparam int PEAK_W    = 7;
  localparam int BREATH_W  = ROM_W + PEAK_W;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_FULL = 1'b0;
  localparam logic REG_DIM  = 1'b1;

  // Color constants.
  localparam logic [COLOR_W-1:0] COL_MAX      = 8'd255;
  localparam logic [COLOR_W-1:0] COL_AMBER    = 8'd200;
  localparam logic [COLOR_W-1:0] COL_ORANGE   = 8'd100;
  localparam logic [PEAK_W-1:0]  PEAK_BLUE    = 7'd80;
  localparam logic [PEAK_W-1:0]  PEAK_GREEN   = 7'd40;
  localparam logic [BRIGHT_W:0]  SCALE_DIV    = 9'd255;
  localparam logic [BRIGHT_W-1:0] FULL_RESET  = 8'd255;
  localparam logic [BRIGHT_W-1:0] DIM_RESET   = 8'd64;
  localparam logic [ELAPSED_W-1:0] BLINK_SAT  = 10'd1023;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_ALERT    = 3'd1,
    CMD_MODE     = 3'd2,
    CMD_MODALITY = 3'd3,
    CMD_BATTERY  = 3'd4,
    CMD_CAP_ON   = 3'd5,
    CMD_CAP_OFF  = 3'd6
  } cmd_e;

  // Alert, mode and modality codes.
  localparam logic [CODE_W-1:0] ALR_CLEAR      = 3'd0;
  localparam logic [CODE_W-1:0] ALR_LOW        = 3'd1;
  localparam logic [CODE_W-1:0] ALR_MID        = 3'd2;
  localparam logic [CODE_W-1:0] ALR_HIGH       = 3'd3;
  localparam logic [CODE_W-1:0] ALR_SEVERE     = 3'd4;
  localparam logic [CODE_W-1:0] MODE_MONITOR   = 3'd0;
  localparam logic [CODE_W-1:0] MODE_PRESENT   = 3'd1;
  localparam logic [CODE_W-1:0] MODE_SLEEP     = 3'd2;
  localparam logic [CODE_W-1:0] MODALITY_BOTH  = 3'd0;
  localparam logic [CODE_W-1:0] MODALITY_VIB   = 3'd1;

  // Words moved by the two channels.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } out_word_t;

  // Controller sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BREATH,
    ST_LOAD,
    ST_SCALE,
    ST_HOLD
  } state_e;

  // Scaling lane states.
  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV,
    LN_DONE
  } lane_state_e;

  // Breathing table: (1 + sin) / 2 in unsigned Q1.15.
  typedef logic [SINE_ENTRIES-1:0][ROM_W-1:0] sine_rom_t;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;

  // Quarter-wave sine of a Q30 argument, odd ninth-order polynomial.
  function automatic logic [63:0] quarter_sine(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] acc;
    z2  = (z * z) >> 30;
    acc = 64'd172272;
    acc = 64'd5026995 - ((z2 * acc) >> 30);
    acc = 64'd85569306 - ((z2 * acc) >> 30);
    acc = 64'd693598669 - ((z2 * acc) >> 30);
    acc = 64'd1686629713 - ((z2 * acc) >> 30);
    acc = (z * acc) >> 30;
    return (acc > Q30_ONE) ? Q30_ONE : acc;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] t;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] pos;
    logic [63:0] s;
    logic [63:0] v;
    rom = '0;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t    = 64'(4 * k);
      quad = t / SINE_ENTRIES;
      rem  = t % SINE_ENTRIES;
      pos  = quad[0] ? (64'(SINE_ENTRIES) - rem) : rem;
      s    = quarter_sine((pos << 30) / SINE_ENTRIES);
      v    = (quad >= 64'd2) ? (Q30_ONE - s) : (Q30_ONE + s);
      rom[k] = ROM_W'((v + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/status_led_color_controller.sv -----
// ----------------------------------------------------------------------------
// Status LED color controller
// A tick word that causes no refresh, and every other command word, goes
// through unstalled. A refresh tick stalls the input until its color is in
// the output register; when breathing, a seven-step serial multiply of the
// sine word runs before the 24-step serial scale lanes. Reset restores all
// levels, counters and brightness registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module status_led_color_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Event input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  slcc_pkg::in_word_t             in_data_i,
  // Color output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output slcc_pkg::out_word_t            out_data_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [slcc_pkg::ADDR_W-1:0]    paddr,
  input  logic [slcc_pkg::DATA_W-1:0]    pwdata,
  output logic [slcc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  // Configuration registers.
  logic [slcc_pkg::BRIGHT_W-1:0] full_bright_q;
  logic [slcc_pkg::BRIGHT_W-1:0] dim_bright_q;

  // Status state.
  logic [slcc_pkg::CODE_W-1:0]    alert_level_q;
  logic [slcc_pkg::CODE_W-1:0]    device_mode_q;
  logic [slcc_pkg::CODE_W-1:0]    modality_q;
  logic                           dimmed_q;
  logic                           capture_q;
  logic [slcc_pkg::REFRESH_W-1:0] refresh_q;
  logic [slcc_pkg::PHASE_W-1:0]   phase_q;
  logic [slcc_pkg::ELAPSED_W-1:0] elapsed_q;
  logic                           lit_q;

  // Sequencer and per-refresh work registers.
  slcc_pkg::state_e               state_q, state_d;
  slcc_pkg::out_word_t            base_q;
  logic                           breath_en_q;
  logic                           breath_blue_q;
  logic [slcc_pkg::PEAK_W-1:0]    peak_q;
  logic [slcc_pkg::BREATH_W-1:0]  breath_acc_q;
  logic [slcc_pkg::STEP_W-1:0]    breath_step_q;
  logic                           out_valid_q;
  slcc_pkg::out_word_t            out_data_q;

  // Combinational helpers.
  logic                           in_accept;
  logic                           is_tick;
  logic [slcc_pkg::PHASE_W-1:0]   phase_inc;
  logic [slcc_pkg::ELAPSED_W-1:0] elapsed_inc;
  logic [slcc_pkg::REFRESH_W-1:0] refresh_inc;
  logic                           refresh_hit;
  logic                           crit_path;
  logic                           blink_flip;
  logic                           lit_new;
  slcc_pkg::out_word_t            base_sel;
  logic                           breath_sel;
  logic                           breath_blue_sel;
  logic [slcc_pkg::PEAK_W-1:0]    peak_sel;
  logic [slcc_pkg::IDXP_W-1:0]    idx_full;
  logic [slcc_pkg::IDX_W-1:0]     rom_idx;
  logic [slcc_pkg::ROM_W-1:0]     rom_word;
  logic                           breath_last;
  logic [slcc_pkg::COLOR_W-1:0]   breath_level;
  logic                           lane_start;
  logic [slcc_pkg::BRIGHT_W-1:0]  bright_sel;
  logic [slcc_pkg::COLOR_W-1:0]   lane_val_r, lane_val_g, lane_val_b;
  logic [2:0]                     lane_done;
  logic                           lanes_done;
  slcc_pkg::out_word_t            lane_res;
  logic                           out_free;
  logic                           out_load;
  logic                           cfg_write;

  // Configuration port access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == slcc_pkg::REG_DIM) ? slcc_pkg::DATA_W'(dim_bright_q)
                                                     : slcc_pkg::DATA_W'(full_bright_q);

  assign in_accept = in_valid_i && !in_stall_o;
  assign is_tick   = (in_data_i.cmd == slcc_pkg::CMD_TICK);

  // Tick counters.
  always_comb begin
    phase_inc = phase_q + 1'b1;
    if (phase_inc >= slcc_pkg::PHASE_W'(slcc_pkg::BREATHE_PERIOD_MS)) begin
      phase_inc = '0;
    end
    elapsed_inc = (elapsed_q < slcc_pkg::BLINK_SAT) ? elapsed_q + 1'b1 : elapsed_q;
    refresh_inc = refresh_q + 1'b1;
    refresh_hit = is_tick
                  && (refresh_inc >= slcc_pkg::REFRESH_W'(slcc_pkg::REFRESH_INTERVAL_MS));
  end

  // Color choice by priority for the refresh that this tick causes.
  always_comb begin
    base_sel        = '0;
    breath_sel      = 1'b0;
    breath_blue_sel = 1'b0;
    peak_sel        = slcc_pkg::PEAK_GREEN;
    crit_path       = 1'b0;
    blink_flip      = (elapsed_inc > slcc_pkg::ELAPSED_W'(slcc_pkg::BLINK_HALF_MS));
    lit_new         = blink_flip ? !lit_q : lit_q;
    priority if (capture_q) begin
      base_sel.red  = slcc_pkg::COL_MAX;
      base_sel.blue = slcc_pkg::COL_MAX;
    end else if (device_mode_q == slcc_pkg::MODE_PRESENT) begin
      breath_sel      = 1'b1;
      breath_blue_sel = 1'b1;
      peak_sel        = slcc_pkg::PEAK_BLUE;
    end else if (device_mode_q == slcc_pkg::MODE_SLEEP) begin
      base_sel = '0;
    end else if (modality_q == slcc_pkg::MODALITY_VIB) begin
      breath_sel = 1'b1;
    end else begin
      unique case (alert_level_q)
        slcc_pkg::ALR_CLEAR: breath_sel = 1'b1;
        slcc_pkg::ALR_LOW: begin
          base_sel.red   = slcc_pkg::COL_MAX;
          base_sel.green = slcc_pkg::COL_AMBER;
        end
        slcc_pkg::ALR_MID: begin
          base_sel.red   = slcc_pkg::COL_MAX;
          base_sel.green = slcc_pkg::COL_ORANGE;
        end
        slcc_pkg::ALR_HIGH: base_sel.red = slcc_pkg::COL_MAX;
        slcc_pkg::ALR_SEVERE: begin
          crit_path    = 1'b1;
          base_sel.red = lit_new ? slcc_pkg::COL_MAX : '0;
        end
        default: base_sel = '0;
      endcase
    end
  end

  // Sine table lookup from the stored phase.
  always_comb begin
    idx_full = (slcc_pkg::IDXP_W'(phase_q) * slcc_pkg::IDXP_W'(slcc_pkg::SINE_ENTRIES))
               / slcc_pkg::IDXP_W'(slcc_pkg::BREATHE_PERIOD_MS);
    if (idx_full >= slcc_pkg::IDXP_W'(slcc_pkg::SINE_ENTRIES)) begin
      rom_idx = slcc_pkg::IDX_W'(slcc_pkg::SINE_ENTRIES - 1);
    end else begin
      rom_idx = idx_full[slcc_pkg::IDX_W-1:0];
    end
    rom_word = slcc_pkg::SINE_ROM[rom_idx];
  end

  assign breath_last  = (breath_step_q == slcc_pkg::STEP_W'(slcc_pkg::PEAK_W - 1));
  assign breath_level = breath_acc_q[slcc_pkg::ROM_FRAC +: slcc_pkg::COLOR_W];

  // Lane operands: the breathing level replaces its channel.
  always_comb begin
    bright_sel = dimmed_q ? dim_bright_q : full_bright_q;
    lane_val_r = base_q.red;
    lane_val_g = (breath_en_q && !breath_blue_q) ? breath_level : base_q.green;
    lane_val_b = (breath_en_q && breath_blue_q) ? breath_level : base_q.blue;
  end

  slcc_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .value_i  (lane_val_r),
    .bright_i (bright_sel),
    .done_o   (lane_done[0]),
    .result_o (lane_res.red)
  );

  slcc_lane u_lane_g (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .value_i  (lane_val_g),
    .bright_i (bright_sel),
    .done_o   (lane_done[1]),
    .result_o (lane_res.green)
  );

  slcc_lane u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lane_start),
    .value_i  (lane_val_b),
    .bright_i (bright_sel),
    .done_o   (lane_done[2]),
    .result_o (lane_res.blue)
  );

  assign lanes_done = &lane_done;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slcc_pkg::ST_IDLE: begin
        if (in_accept && refresh_hit) begin
          state_d = breath_sel ? slcc_pkg::ST_BREATH : slcc_pkg::ST_LOAD;
        end
      end
      slcc_pkg::ST_BREATH: if (breath_last) state_d = slcc_pkg::ST_LOAD;
      slcc_pkg::ST_LOAD:   state_d = slcc_pkg::ST_SCALE;
      slcc_pkg::ST_SCALE: begin
        if (lanes_done) begin
          state_d = out_free ? slcc_pkg::ST_IDLE : slcc_pkg::ST_HOLD;
        end
      end
      slcc_pkg::ST_HOLD:   if (out_free) state_d = slcc_pkg::ST_IDLE;
      default:             state_d = slcc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != slcc_pkg::ST_IDLE);
    lane_start = (state_q == slcc_pkg::ST_LOAD);
    out_load   = out_free && ((state_q == slcc_pkg::ST_SCALE && lanes_done)
                              || state_q == slcc_pkg::ST_HOLD);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_bright_q <= slcc_pkg::FULL_RESET;
      dim_bright_q  <= slcc_pkg::DIM_RESET;
      alert_level_q <= slcc_pkg::ALR_CLEAR;
      device_mode_q <= slcc_pkg::MODE_MONITOR;
      modality_q    <= slcc_pkg::MODALITY_BOTH;
      dimmed_q      <= 1'b0;
      capture_q     <= 1'b0;
      refresh_q     <= '0;
      phase_q       <= '0;
      elapsed_q     <= '0;
      lit_q         <= 1'b1;
      state_q       <= slcc_pkg::ST_IDLE;
      breath_step_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_write) begin
        if (paddr[2] == slcc_pkg::REG_DIM) begin
          dim_bright_q <= pwdata[slcc_pkg::BRIGHT_W-1:0];
        end else begin
          full_bright_q <= pwdata[slcc_pkg::BRIGHT_W-1:0];
        end
      end

      if (in_accept) begin
        unique case (in_data_i.cmd)
          slcc_pkg::CMD_TICK: begin
            phase_q <= phase_inc;
            if (refresh_hit) begin
              refresh_q <= '0;
            end else begin
              refresh_q <= refresh_inc;
            end
            if (refresh_hit && crit_path && blink_flip) begin
              elapsed_q <= '0;
              lit_q     <= lit_new;
            end else begin
              elapsed_q <= elapsed_inc;
            end
          end
          slcc_pkg::CMD_ALERT:    alert_level_q <= in_data_i.payload;
          slcc_pkg::CMD_MODE:     device_mode_q <= in_data_i.payload;
          slcc_pkg::CMD_MODALITY: modality_q    <= in_data_i.payload;
          slcc_pkg::CMD_BATTERY:  dimmed_q      <= 1'b1;
          slcc_pkg::CMD_CAP_ON:   capture_q     <= 1'b1;
          slcc_pkg::CMD_CAP_OFF:  capture_q     <= 1'b0;
          default: begin
          end
        endcase
      end

      if (state_q == slcc_pkg::ST_BREATH) begin
        breath_step_q <= breath_step_q + 1'b1;
      end else begin
        breath_step_q <= '0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-refresh work registers and the serial breathing multiply.
  always_ff @(posedge clk_i) begin
    if (in_accept && refresh_hit) begin
      base_q        <= base_sel;
      breath_en_q   <= breath_sel;
      breath_blue_q <= breath_blue_sel;
      peak_q        <= peak_sel;
      breath_acc_q  <= '0;
    end else if (state_q == slcc_pkg::ST_BREATH) begin
      breath_acc_q <= {breath_acc_q[slcc_pkg::BREATH_W-2:0], 1'b0}
                      + (peak_q[slcc_pkg::PEAK_W-1]
                         ? slcc_pkg::BREATH_W'(rom_word) : '0);
      peak_q       <= {peak_q[slcc_pkg::PEAK_W-2:0], 1'b0};
    end
    if (out_load) begin
      out_data_q <= lane_res;
    end
  end

`ifndef SYNTHESIS
  // The refresh counter always clears before reaching the interval.
  a_refresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh_q < slcc_pkg::REFRESH_W'(slcc_pkg::REFRESH_INTERVAL_MS))
    else $error("refresh counter out of range");

  // The breathing phase wraps inside its period.
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < slcc_pkg::PHASE_W'(slcc_pkg::BREATHE_PERIOD_MS))
    else $error("breathing phase out of range");

  // Lanes only finish while the sequencer waits for them.
  a_lane_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lanes_done |-> state_q == slcc_pkg::ST_SCALE)
    else $error("scale lanes finished outside the scale state");

  // A refresh tick starts a color computation.
  a_refresh_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && refresh_hit) |=>
      (state_q == slcc_pkg::ST_BREATH || state_q == slcc_pkg::ST_LOAD))
    else $error("refresh tick did not start a color computation");
`endif

endmodule

// ----- rtl/slcc_lane.sv -----
// ----------------------------------------------------------------------------
// Status LED color scaling lane
// Computes value * brightness / 255 (floor) bit-serially: a shift-add
// multiply over the brightness bits, then a restoring divide by 255.
// ----------------------------------------------------------------------------
module slcc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slcc_pkg::COLOR_W-1:0]  value_i,
  input  logic [slcc_pkg::BRIGHT_W-1:0] bright_i,
  output logic                          done_o,
  output logic [slcc_pkg::COLOR_W-1:0]  result_o
);

  slcc_pkg::lane_state_e state_q, state_d;

  logic [slcc_pkg::STEP_W-1:0]   step_q;
  logic [slcc_pkg::BRIGHT_W-1:0] bright_q;
  logic [slcc_pkg::COLOR_W-1:0]  value_q;
  logic [slcc_pkg::PROD_W-1:0]   prod_q;
  logic [slcc_pkg::COLOR_W-1:0]  rem_q;
  logic [slcc_pkg::COLOR_W-1:0]  quot_q;

  logic                          mul_last;
  logic                          div_last;
  logic [slcc_pkg::COLOR_W:0]    trial;
  logic                          qbit;
  logic [slcc_pkg::COLOR_W-1:0]  rem_next;

  assign mul_last = (step_q == slcc_pkg::STEP_W'(slcc_pkg::BRIGHT_W - 1));
  assign div_last = (step_q == slcc_pkg::STEP_W'(slcc_pkg::PROD_W - 1));

  // One divide step: bring down the next product bit and compare with 255.
  always_comb begin
    trial = {rem_q, prod_q[slcc_pkg::PROD_W-1]};
    qbit  = (trial >= slcc_pkg::SCALE_DIV);
    if (qbit) begin
      rem_next = slcc_pkg::COLOR_W'(trial - slcc_pkg::SCALE_DIV);
    end else begin
      rem_next = trial[slcc_pkg::COLOR_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slcc_pkg::LN_IDLE: if (start_i) state_d = slcc_pkg::LN_MUL;
      slcc_pkg::LN_MUL:  if (mul_last) state_d = slcc_pkg::LN_DIV;
      slcc_pkg::LN_DIV:  if (div_last) state_d = slcc_pkg::LN_DONE;
      slcc_pkg::LN_DONE: state_d = slcc_pkg::LN_IDLE;
      default:           state_d = slcc_pkg::LN_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done_o   = (state_q == slcc_pkg::LN_DONE);
    result_o = quot_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slcc_pkg::LN_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == slcc_pkg::LN_IDLE || (state_q == slcc_pkg::LN_MUL && mul_last)) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      slcc_pkg::LN_IDLE: begin
        if (start_i) begin
          bright_q <= bright_i;
          value_q  <= value_i;
          prod_q   <= '0;
          rem_q    <= '0;
        end
      end
      slcc_pkg::LN_MUL: begin
        prod_q   <= {prod_q[slcc_pkg::PROD_W-2:0], 1'b0}
                    + (bright_q[slcc_pkg::BRIGHT_W-1]
                       ? slcc_pkg::PROD_W'(value_q) : '0);
        bright_q <= {bright_q[slcc_pkg::BRIGHT_W-2:0], 1'b0};
      end
      slcc_pkg::LN_DIV: begin
        prod_q <= {prod_q[slcc_pkg::PROD_W-2:0], 1'b0};
        rem_q  <= rem_next;
        quot_q <= {quot_q[slcc_pkg::COLOR_W-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- dv/status_led_color_controller_tb.sv -----
// ----------------------------------------------------------------------------
// Status LED color controller testbench
// Drives event words (ticks, alert, mode and modality changes, battery low,
// capture start and stop) into the controller and predicts every refresh
// color in a scoreboard. Colors are compared field by field in order. The run
// goes through several brightness settings written over the APB port, with
// random idle gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module status_led_color_controller_tb;

  // Timing of the behavior being predicted.
  localparam int unsigned BREATH_PERIOD = 2048;
  localparam int unsigned SINE_N        = 256;
  localparam int unsigned REFRESH_TICKS = 20;
  localparam int unsigned BLINK_HALF    = 500;
  localparam int unsigned BLINK_MAX     = 1023;

  // Color levels and breathing peaks.
  localparam int unsigned LVL_FULL   = 255;
  localparam int unsigned LVL_AMBER  = 200;
  localparam int unsigned LVL_ORANGE = 100;
  localparam int unsigned LVL_NONE   = 0;
  localparam int unsigned BLUE_PEAK  = 80;
  localparam int unsigned GREEN_PEAK = 40;
  localparam longint unsigned Q30    = 64'd1073741824;

  // Command code that the block ignores.
  localparam logic [slcc_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  // Register addresses on the configuration port.
  localparam logic [slcc_pkg::ADDR_W-1:0] FULL_ADDR = {slcc_pkg::REG_FULL, 2'b00};
  localparam logic [slcc_pkg::ADDR_W-1:0] DIM_ADDR  = {slcc_pkg::REG_DIM, 2'b00};

  // Run shape.
  localparam int NUM_PHASES       = 8;
  localparam int WORDS_PER_PHASE  = 100;
  localparam int SETTLE_CYCLES    = 64;
  localparam int unsigned MAX_CYCLES = 300000;
  localparam int BATTERY_PHASE    = 4;

  // Brightness settings per phase; phase 0 keeps the reset values.
  logic [7:0] full_set [NUM_PHASES] = '{8'd255, 8'd0, 8'd255, 8'd1,
                                        8'd170, 8'd255, 8'd200, 8'd37};
  logic [7:0] dim_set  [NUM_PHASES] = '{8'd64, 8'd0, 8'd255, 8'd128,
                                        8'd64, 8'd255, 8'd0, 8'd1};

  // Predicts the refresh colors and holds the ones not yet seen.
  class led_color_model;
    int unsigned breath_rom [SINE_N];
    int unsigned full_br;
    int unsigned dim_br;
    logic [slcc_pkg::CODE_W-1:0] alert;
    logic [slcc_pkg::CODE_W-1:0] mode;
    logic [slcc_pkg::CODE_W-1:0] modality;
    bit dimmed;
    bit capture;
    int unsigned refresh_cnt;
    int unsigned breath_pos;
    int unsigned blink_cnt;
    bit blink_on;
    slcc_pkg::out_word_t color_q [$];
    int errors;
    int colors_seen;
    int words_seen;
    int blink_toggles;

    function new();
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned pos;
      longint unsigned s;
      longint unsigned v;
      // Breathing table: (1 + sin) / 2 in unsigned Q1.15, from a quarter wave.
      for (int k = 0; k < SINE_N; k++) begin
        quad = (4 * k) / SINE_N;
        rem  = (4 * k) % SINE_N;
        pos  = quad[0] ? (SINE_N - rem) : rem;
        s    = sine_q30((pos << 30) / SINE_N);
        v    = (quad >= 2) ? (Q30 - s) : (Q30 + s);
        breath_rom[k] = int'((v + 64'd32768) >> 16);
      end
      full_br    = 255;
      dim_br     = 64;
      alert      = slcc_pkg::ALR_CLEAR;
      mode       = slcc_pkg::MODE_MONITOR;
      modality   = slcc_pkg::MODALITY_BOTH;
      dimmed     = 1'b0;
      capture    = 1'b0;
      refresh_cnt = 0;
      breath_pos = 0;
      blink_cnt  = 0;
      blink_on   = 1'b1;
    endfunction

    // sin(pi/2 * z), z and result in Q30, by Horner on the odd polynomial.
    function longint unsigned sine_q30(longint unsigned z);
      longint unsigned coef [5] = '{64'd172272, 64'd5026995, 64'd85569306,
                                    64'd693598669, 64'd1686629713};
      longint unsigned zsq;
      longint unsigned acc;
      zsq = (z * z) >> 30;
      acc = coef[0];
      for (int i = 1; i < 5; i++) acc = coef[i] - ((zsq * acc) >> 30);
      acc = (z * acc) >> 30;
      return (acc > Q30) ? Q30 : acc;
    endfunction

    function void set_brightness(logic [7:0] full_val, logic [7:0] dim_val);
      full_br = full_val;
      dim_br  = dim_val;
    endfunction

    function int unsigned breathing(int unsigned peak);
      int unsigned idx;
      idx = (breath_pos * SINE_N) / BREATH_PERIOD;
      if (idx >= SINE_N) idx = SINE_N - 1;
      return (peak * breath_rom[idx]) >> 15;
    endfunction

    function slcc_pkg::out_word_t scaled(int unsigned r, int unsigned g, int unsigned b);
      int unsigned br;
      slcc_pkg::out_word_t c;
      br = dimmed ? dim_br : full_br;
      c.red   = 8'((r * br) / 255);
      c.green = 8'((g * br) / 255);
      c.blue  = 8'((b * br) / 255);
      return c;
    endfunction

    // Color chosen by priority at a refresh; critical also runs the blink.
    function slcc_pkg::out_word_t refresh_color();
      slcc_pkg::out_word_t off;
      off = '0;
      if (capture) return scaled(LVL_FULL, LVL_NONE, LVL_FULL);
      if (mode == slcc_pkg::MODE_PRESENT)
        return scaled(LVL_NONE, LVL_NONE, breathing(BLUE_PEAK));
      if (mode == slcc_pkg::MODE_SLEEP) return off;
      if (modality == slcc_pkg::MODALITY_VIB)
        return scaled(LVL_NONE, breathing(GREEN_PEAK), LVL_NONE);
      case (alert)
        slcc_pkg::ALR_CLEAR:  return scaled(LVL_NONE, breathing(GREEN_PEAK), LVL_NONE);
        slcc_pkg::ALR_LOW:    return scaled(LVL_FULL, LVL_AMBER, LVL_NONE);
        slcc_pkg::ALR_MID:    return scaled(LVL_FULL, LVL_ORANGE, LVL_NONE);
        slcc_pkg::ALR_HIGH:   return scaled(LVL_FULL, LVL_NONE, LVL_NONE);
        slcc_pkg::ALR_SEVERE: begin
          if (blink_cnt > BLINK_HALF) begin
            blink_on  = !blink_on;
            blink_cnt = 0;
            blink_toggles++;
          end
          return blink_on ? scaled(LVL_FULL, LVL_NONE, LVL_NONE) : off;
        end
        default:              return off;
      endcase
    endfunction

    // Updates the state for one accepted event word.
    function void accept_event(slcc_pkg::in_word_t w);
      words_seen++;
      case (w.cmd)
        slcc_pkg::CMD_TICK: begin
          breath_pos = (breath_pos + 1 >= BREATH_PERIOD) ? 0 : breath_pos + 1;
          if (blink_cnt < BLINK_MAX) blink_cnt++;
          refresh_cnt++;
          if (refresh_cnt >= REFRESH_TICKS) begin
            refresh_cnt = 0;
            color_q.push_back(refresh_color());
          end
        end
        slcc_pkg::CMD_ALERT:    alert = w.payload;
        slcc_pkg::CMD_MODE:     mode = w.payload;
        slcc_pkg::CMD_MODALITY: modality = w.payload;
        slcc_pkg::CMD_BATTERY:  dimmed = 1'b1;
        slcc_pkg::CMD_CAP_ON:   capture = 1'b1;
        slcc_pkg::CMD_CAP_OFF:  capture = 1'b0;
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compares one accepted color with the oldest prediction.
    function void compare_color(slcc_pkg::out_word_t got);
      slcc_pkg::out_word_t want;
      if (color_q.size() == 0) begin
        report($sformatf("color r=%0d g=%0d b=%0d arrived with none predicted",
                         got.red, got.green, got.blue));
        return;
      end
      want = color_q.pop_front();
      colors_seen++;
      if (got.red !== want.red)
        report($sformatf("color %0d red: expected %0d, got %0d",
                         colors_seen, want.red, got.red));
      if (got.green !== want.green)
        report($sformatf("color %0d green: expected %0d, got %0d",
                         colors_seen, want.green, got.green));
      if (got.blue !== want.blue)
        report($sformatf("color %0d blue: expected %0d, got %0d",
                         colors_seen, want.blue, got.blue));
    endfunction

    function int pending();
      return color_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  slcc_pkg::in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  slcc_pkg::out_word_t out_data_o;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [slcc_pkg::ADDR_W-1:0] paddr;
  logic [slcc_pkg::DATA_W-1:0] pwdata;
  logic [slcc_pkg::DATA_W-1:0] prdata;
  logic      pready;

  led_color_model colors = new();
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_count;

  status_led_color_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls at the rate of the current idle profile.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Color monitor: a word is taken when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) colors.compare_color(out_data_o);
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic slcc_pkg::in_word_t make_word(logic [slcc_pkg::CMD_W-1:0] cmd,
                                                   logic [slcc_pkg::CODE_W-1:0] pay);
    slcc_pkg::in_word_t w;
    w.cmd     = cmd;
    w.payload = pay;
    return w;
  endfunction

  // Mostly ticks; events lean toward critical alerts and known codes.
  function automatic slcc_pkg::in_word_t random_word(bit allow_battery);
    slcc_pkg::in_word_t w;
    int unsigned pick;
    w.cmd     = slcc_pkg::CMD_TICK;
    w.payload = 3'($urandom);
    if ($urandom_range(99) < 12) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        w.cmd = slcc_pkg::CMD_ALERT;
        if ($urandom_range(1) == 1) w.payload = slcc_pkg::ALR_SEVERE;
      end else if (pick < 50) begin
        w.cmd = slcc_pkg::CMD_MODE;
        if ($urandom_range(1) == 1) w.payload = slcc_pkg::MODE_MONITOR;
      end else if (pick < 65) begin
        w.cmd = slcc_pkg::CMD_MODALITY;
        if ($urandom_range(1) == 1) w.payload = slcc_pkg::MODALITY_BOTH;
      end else if (pick < 73) begin
        w.cmd = slcc_pkg::CMD_CAP_ON;
      end else if (pick < 87) begin
        w.cmd = slcc_pkg::CMD_CAP_OFF;
      end else if (pick < 92) begin
        w.cmd = allow_battery ? slcc_pkg::CMD_BATTERY : slcc_pkg::CMD_CAP_OFF;
      end else begin
        w.cmd = CMD_UNUSED;
      end
    end
    return w;
  endfunction

  // Sends one event word, with a random idle gap before it.
  task automatic send_word(input slcc_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    colors.accept_event(w);
  endtask

  // Holds the input until every predicted color has come, then lets the
  // block finish any work that produces no color.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (colors.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  task automatic write_reg(input logic [slcc_pkg::ADDR_W-1:0] addr, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Main stimulus.
  initial begin
    slcc_pkg::in_word_t w;
    int       sent;
    int       failures;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unknown codes, ignored command and capture toggling at reset brightness,
    // then one refresh that must show the unknown alert level as off.
    send_word(make_word(slcc_pkg::CMD_ALERT, 3'd7));
    send_word(make_word(slcc_pkg::CMD_MODALITY, 3'd7));
    send_word(make_word(slcc_pkg::CMD_MODE, 3'd7));
    send_word(make_word(CMD_UNUSED, 3'd7));
    send_word(make_word(slcc_pkg::CMD_CAP_ON, 3'd0));
    send_word(make_word(slcc_pkg::CMD_CAP_OFF, 3'd0));
    for (int i = 0; i < REFRESH_TICKS; i++)
      send_word(make_word(slcc_pkg::CMD_TICK, (i % 2 == 0) ? 3'd0 : 3'd7));

    // Random phases over brightness settings and idle profiles.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph != 0) begin
        write_reg(FULL_ADDR, full_set[ph]);
        write_reg(DIM_ADDR, dim_set[ph]);
        colors.set_brightness(full_set[ph], dim_set[ph]);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (ph == BATTERY_PHASE) send_word(make_word(slcc_pkg::CMD_BATTERY, 3'($urandom)));
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        w = random_word(ph >= BATTERY_PHASE);
        send_word(w);
        if (w.cmd != CMD_UNUSED) sent++;
      end
    end

    settle();
    failures = colors.errors + colors.pending();
    $display("Checked %0d colors from %0d event words over %0d brightness settings,",
             colors.colors_seen, colors.words_seen, NUM_PHASES);
    $display("with battery dimming, four idle profiles and %0d critical blink toggles.",
             colors.blink_toggles);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
